/* rtl/vas_pkg.sv */
// Package for the valve actuator supervisor: request, response and state types,
// state codes, register indexes and reset values. No dependencies.
package vas_pkg;

   // State codes carried in ctrl_state and reported as state_code
   localparam logic [2:0] ST_INIT    = 3'd0;
   localparam logic [2:0] ST_CLOSED  = 3'd1;
   localparam logic [2:0] ST_OPENING = 3'd2;
   localparam logic [2:0] ST_OPEN    = 3'd3;
   localparam logic [2:0] ST_CLOSING = 3'd4;
   localparam logic [2:0] ST_FAILED  = 3'd5;
   localparam logic [2:0] ST_NONE    = 3'd7;

   // Configuration register indexes
   localparam logic CSR_MOVE_TIMEOUT = 1'b0;
   localparam logic CSR_FAIL_HOLD    = 1'b1;

   // Configuration reset values
   localparam logic [15:0] MOVE_TIMEOUT_RST = 16'd10000;
   localparam logic [15:0] FAIL_HOLD_RST    = 16'd1000;

   typedef struct packed {
      logic closed_switch;
      logic open_switch;
      logic blocked;
      logic open_request;
      logic close_request;
   } req_type;

   typedef struct packed {
      logic       drive_open;
      logic       drive_close;
      logic       failed;
      logic [2:0] state_code;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  ctrl_state;
      logic [2:0]  prior_state;
      logic [15:0] tick_count;
      logic        open_drive;
      logic        close_drive;
   } sup_state_type;

   typedef struct packed {
      logic [15:0] move_timeout;
      logic [15:0] fail_hold;
   } cfg_type;

endpackage

/* rtl/valve_actuator_supervisor.sv */
// Valve actuator supervisor top level: request register, tick logic, response register
// and configuration registers. Depends on vas_pkg and vas_step.
//
//   channel  | ports                          | direction | payload
//   request  | req_valid, req_stall, req_data | in        | req_type (switches, commands)
//   response | rsp_valid, rsp_stall, rsp_data | out       | rsp_type (drives, failed, state)
//   csr      | csr_we, csr_index, csr_wdata   | in        | 16-bit limit registers
//
// One request per cycle sustained while the response does not stall. A request passes
// through the request register, a tick of logic and the response register, in order.
// The supervisor state updates as a request moves into the response register.
// A stalled response holds; the request register keeps accepting while the response
// register drains; requests stall only while both are full and the response stalls.
// Synchronous reset returns to init with both drives off and default limits.
module valve_actuator_supervisor import vas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic          req_valid_ff;
   req_type       req_data_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   sup_state_type sup_ff;
   sup_state_type sup_in;
   rsp_type       rsp_in;
   cfg_type       cfg_ff;
   logic          advance;
   logic          req_take;

   // Move a request into the response register when that slot is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   vas_step u_step (
      .cur_state (sup_ff),
      .req_item  (req_data_ff),
      .cfg       (cfg_ff),
      .nxt_state (sup_in),
      .rsp_item  (rsp_in)
   );

   // Hold the request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
      if (req_take) req_data_ff <= req_data;
   end

   // Hold the response register and advance the supervisor state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff       <= 1'b0;
         sup_ff.ctrl_state  <= ST_INIT;
         sup_ff.prior_state <= ST_NONE;
         sup_ff.tick_count  <= 16'd0;
         sup_ff.open_drive  <= 1'b0;
         sup_ff.close_drive <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
         sup_ff       <= sup_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) rsp_data_ff <= rsp_in;
   end

   // Write the limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_timeout <= MOVE_TIMEOUT_RST;
         cfg_ff.fail_hold    <= FAIL_HOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MOVE_TIMEOUT: cfg_ff.move_timeout <= csr_wdata;
            CSR_FAIL_HOLD:    cfg_ff.fail_hold    <= csr_wdata;
            default:          cfg_ff.fail_hold    <= cfg_ff.fail_hold;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/vas_step.sv */
// One supervisor tick: next state and response from the current state and one request.
// Depends on vas_pkg.
module vas_step import vas_pkg::*; (
   input  sup_state_type cur_state,
   input  req_type       req_item,
   input  cfg_type       cfg,
   output sup_state_type nxt_state,
   output rsp_type       rsp_item
);

   logic        entry;
   logic        force_fail;
   logic [2:0]  eff_state;
   logic [15:0] cnt_base;
   logic [15:0] cnt_limit;
   logic [16:0] cnt_inc;
   logic        cnt_over;
   logic [15:0] cnt_sat;

   // Detect state entry before the forced-failure check
   assign entry      = (cur_state.ctrl_state != cur_state.prior_state);
   assign force_fail = (req_item.closed_switch == req_item.open_switch) || req_item.blocked;
   assign eff_state  = force_fail ? ST_FAILED : cur_state.ctrl_state;

   // Saturating tick counter against the limit of the current state
   assign cnt_base  = entry ? 16'd0 : cur_state.tick_count;
   assign cnt_limit = (eff_state == ST_FAILED) ? cfg.fail_hold : cfg.move_timeout;
   assign cnt_inc   = {1'b0, cnt_base} + 17'd1;
   assign cnt_over  = (cnt_inc > {1'b0, cnt_limit});
   assign cnt_sat   = cnt_over ? cnt_limit : cnt_inc[15:0];

   // Advance the state machine by one tick
   always_comb begin
      nxt_state             = cur_state;
      nxt_state.prior_state = cur_state.ctrl_state;
      nxt_state.ctrl_state  = eff_state;
      unique case (eff_state)
         ST_INIT: begin
            if (entry) begin
               nxt_state.open_drive  = 1'b0;
               nxt_state.close_drive = 1'b0;
               nxt_state.tick_count  = 16'd0;
            end
            if (req_item.closed_switch) nxt_state.ctrl_state = ST_CLOSED;
            if (req_item.open_switch)   nxt_state.ctrl_state = ST_OPEN;
         end
         ST_CLOSED: begin
            if (entry) nxt_state.tick_count = 16'd0;
            if (req_item.open_switch)  nxt_state.ctrl_state = ST_FAILED;
            if (req_item.open_request) nxt_state.ctrl_state = ST_OPENING;
         end
         ST_OPENING: begin
            if (entry) begin
               nxt_state.open_drive  = 1'b1;
               nxt_state.close_drive = 1'b0;
            end
            nxt_state.tick_count = cnt_sat;
            if (req_item.open_switch) nxt_state.ctrl_state = ST_OPEN;
            if (cnt_over)             nxt_state.ctrl_state = ST_FAILED;
         end
         ST_OPEN: begin
            if (entry) nxt_state.tick_count = 16'd0;
            if (req_item.closed_switch) nxt_state.ctrl_state = ST_FAILED;
            if (req_item.close_request) nxt_state.ctrl_state = ST_CLOSING;
         end
         ST_CLOSING: begin
            if (entry) begin
               nxt_state.close_drive = 1'b1;
               nxt_state.open_drive  = 1'b0;
            end
            nxt_state.tick_count = cnt_sat;
            if (req_item.closed_switch) nxt_state.ctrl_state = ST_CLOSED;
            if (cnt_over)               nxt_state.ctrl_state = ST_FAILED;
         end
         ST_FAILED: begin
            if (entry) begin
               nxt_state.open_drive  = 1'b0;
               nxt_state.close_drive = 1'b0;
            end
            nxt_state.tick_count = cnt_sat;
            if (cnt_over) begin
               if (req_item.closed_switch) nxt_state.ctrl_state = ST_CLOSED;
               if (req_item.open_switch)   nxt_state.ctrl_state = ST_OPEN;
            end
         end
         default: begin
            // unused codes only track entry
         end
      endcase
   end

   // Build the response from the updated state; failed marks a tick spent in failed
   assign rsp_item.drive_open  = nxt_state.open_drive;
   assign rsp_item.drive_close = nxt_state.close_drive;
   assign rsp_item.failed      = (eff_state == ST_FAILED);
   assign rsp_item.state_code  = nxt_state.ctrl_state;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for valve_actuator_supervisor: directed and random ticks are checked against
// a tick-by-tick prediction of the supervisor, with random request gaps and response stalls.
// Depends on vas_pkg and the valve_actuator_supervisor RTL.
module testbench;
   import vas_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_OFF     = 300;
   localparam int PHASES       = 10;

   // Tracks the supervisor tick by tick and keeps the outputs still to come
   class supervisor_tracker;
      logic [15:0] timeout_limit;
      logic [15:0] hold_limit;
      logic [2:0]  sup_state;
      logic [2:0]  last_state;
      logic [15:0] travel_count;
      logic        open_cmd;
      logic        close_cmd;
      rsp_type     due_outputs[$];
      int          mismatches;

      function new();
         timeout_limit = MOVE_TIMEOUT_RST;
         hold_limit    = FAIL_HOLD_RST;
         sup_state     = ST_INIT;
         last_state    = ST_NONE;
         travel_count  = '0;
         open_cmd      = 1'b0;
         close_cmd     = 1'b0;
         mismatches    = 0;
      endfunction

      function void set_limits(logic [15:0] timeout_val, logic [15:0] hold_val);
         timeout_limit = timeout_val;
         hold_limit    = hold_val;
      endfunction

      function int pending();
         return due_outputs.size();
      endfunction

      // Count one tick; hold the count at the limit and report when it is passed
      function bit advance_count(logic [15:0] limit);
         logic [16:0] next_count;
         next_count = {1'b0, travel_count} + 17'd1;
         if (next_count > {1'b0, limit}) begin
            travel_count = limit;
            return 1'b1;
         end
         travel_count = next_count[15:0];
         return 1'b0;
      endfunction

      // Step the supervisor by one accepted request and queue its outputs
      function void note_tick(req_type r);
         bit      entry;
         bit      timed_out;
         rsp_type want;
         entry      = (sup_state != last_state);
         last_state = sup_state;
         // force failure on equal switches or an external block
         if (r.closed_switch == r.open_switch || r.blocked) sup_state = ST_FAILED;
         want.failed = (sup_state == ST_FAILED);
         case (sup_state)
            ST_INIT: begin
               if (entry) begin
                  open_cmd     = 1'b0;
                  close_cmd    = 1'b0;
                  travel_count = '0;
               end
               if (r.closed_switch) sup_state = ST_CLOSED;
               if (r.open_switch) sup_state = ST_OPEN;
            end
            ST_CLOSED: begin
               if (entry) travel_count = '0;
               if (r.open_switch) sup_state = ST_FAILED;
               if (r.open_request) sup_state = ST_OPENING;
            end
            ST_OPENING: begin
               if (entry) begin
                  travel_count = '0;
                  open_cmd     = 1'b1;
                  close_cmd    = 1'b0;
               end
               timed_out = advance_count(timeout_limit);
               if (r.open_switch) sup_state = ST_OPEN;
               if (timed_out) sup_state = ST_FAILED;
            end
            ST_OPEN: begin
               if (entry) travel_count = '0;
               if (r.closed_switch) sup_state = ST_FAILED;
               if (r.close_request) sup_state = ST_CLOSING;
            end
            ST_CLOSING: begin
               if (entry) begin
                  travel_count = '0;
                  close_cmd    = 1'b1;
                  open_cmd     = 1'b0;
               end
               timed_out = advance_count(timeout_limit);
               if (r.closed_switch) sup_state = ST_CLOSED;
               if (timed_out) sup_state = ST_FAILED;
            end
            ST_FAILED: begin
               if (entry) begin
                  open_cmd     = 1'b0;
                  close_cmd    = 1'b0;
                  travel_count = '0;
               end
               // recover once the hold time has run out, following the switches
               if (advance_count(hold_limit)) begin
                  if (r.closed_switch) sup_state = ST_CLOSED;
                  if (r.open_switch) sup_state = ST_OPEN;
               end
            end
            default: ;
         endcase
         want.drive_open  = open_cmd;
         want.drive_close = close_cmd;
         want.state_code  = sup_state;
         due_outputs.push_back(want);
      endfunction

      // Compare one accepted response with the oldest outstanding outputs
      function void check_outputs(rsp_type got);
         rsp_type want;
         if (due_outputs.size() == 0) begin
            $error("response with nothing outstanding: %b", got);
            mismatches++;
            return;
         end
         want = due_outputs.pop_front();
         if (got.drive_open !== want.drive_open) begin
            $error("drive_open: expected %0b, got %0b", want.drive_open, got.drive_open);
            mismatches++;
         end
         if (got.drive_close !== want.drive_close) begin
            $error("drive_close: expected %0b, got %0b", want.drive_close, got.drive_close);
            mismatches++;
         end
         if (got.failed !== want.failed) begin
            $error("failed: expected %0b, got %0b", want.failed, got.failed);
            mismatches++;
         end
         if (got.state_code !== want.state_code) begin
            $error("state_code: expected %0d, got %0d", want.state_code, got.state_code);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   supervisor_tracker tracker;
   bit  jitter_on     = 1'b0;
   bit  hold_off_req  = 1'b0;
   bit  plant_open    = 1'b0;
   int  cycle_count   = 0;

   valve_actuator_supervisor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Abandon the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("valve_actuator_supervisor verification failed");
         $finish;
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_outputs(rsp_data);
   end

   // Response side: random stall bursts, one long hold-off on demand
   initial begin : response_sink
      int hold_left;
      int burst_left;
      bit burst_stall;
      bit stall_next;
      hold_left   = 0;
      burst_left  = 0;
      burst_stall = 1'b0;
      rsp_stall   = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_left    = HOLD_OFF;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
         end else if (!jitter_on) begin
            stall_next = 1'b0;
         end else begin
            if (burst_left == 0) begin
               burst_stall = ($urandom_range(0, 2) == 0);
               burst_left  = burst_stall ? $urandom_range(1, 15) : $urandom_range(1, 30);
            end
            stall_next = burst_stall;
            burst_left--;
         end
         rsp_stall <= stall_next;
      end
   end

   function automatic req_type tick_in(int c, int o, int b, int orq, int crq);
      req_type r;
      r.closed_switch = c[0];
      r.open_switch   = o[0];
      r.blocked       = b[0];
      r.open_request  = orq[0];
      r.close_request = crq[0];
      return r;
   endfunction

   // Mostly switch readings of a valve that travels now and then, some noise
   function automatic req_type random_request();
      logic [4:0] noise;
      req_type    r;
      if ($urandom_range(0, 19) == 0) begin
         noise = 5'($urandom_range(0, 31));
         r     = noise;
         return r;
      end
      if ($urandom_range(0, 24) == 0) plant_open = !plant_open;
      r.closed_switch = !plant_open;
      r.open_switch   = plant_open;
      r.blocked       = ($urandom_range(0, 49) == 0);
      r.open_request  = ($urandom_range(0, 3) == 0);
      r.close_request = ($urandom_range(0, 3) == 0);
      return r;
   endfunction

   // Offer one request, with an occasional idle burst first, and wait for it to go in
   task automatic send_request(input req_type r);
      if (jitter_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_tick(r);
   endtask

   // Drop valid and let every outstanding response drain
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input logic [15:0] timeout_val, input logic [15:0] hold_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_MOVE_TIMEOUT;
      csr_wdata <= timeout_val;
      @(posedge clock);
      csr_index <= CSR_FAIL_HOLD;
      csr_wdata <= hold_val;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_limits(timeout_val, hold_val);
   endtask

   initial begin : stimulus
      logic [15:0] timeout_val;
      logic [15:0] hold_val;
      int          count;
      tracker   = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_MOVE_TIMEOUT;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset    <= 1'b0;
      jitter_on = 1'b1;

      // init to closed with both requests ignored, stray close ignored, then an open request
      send_request(tick_in(1, 0, 0, 1, 1));
      send_request(tick_in(1, 0, 0, 0, 1));
      send_request(tick_in(1, 0, 0, 1, 0));
      repeat (5) send_request(tick_in(1, 0, 0, 0, 0));
      // shrink the timeout under a running count: clamp and fail on the next tick
      settle();
      write_limits(16'd3, 16'd2);
      send_request(tick_in(1, 0, 0, 0, 0));
      // hold in failed, then recover to open
      repeat (3) send_request(tick_in(0, 1, 0, 0, 0));
      // close request beats the closed switch in open, then arrival
      send_request(tick_in(1, 0, 0, 0, 1));
      send_request(tick_in(1, 0, 0, 0, 0));
      // open request beats the open switch in closed, then arrival
      send_request(tick_in(0, 1, 0, 1, 0));
      send_request(tick_in(0, 1, 0, 0, 0));
      // closing where the timeout beats a late arrival
      send_request(tick_in(0, 1, 0, 0, 1));
      repeat (3) send_request(tick_in(0, 1, 0, 0, 0));
      send_request(tick_in(1, 0, 0, 0, 0));
      // block, equal switches, then recover to closed
      send_request(tick_in(1, 0, 1, 1, 1));
      send_request(tick_in(1, 1, 0, 0, 0));
      send_request(tick_in(0, 0, 0, 0, 0));
      repeat (3) send_request(tick_in(1, 0, 0, 0, 0));

      // random phases: extreme limits first, then small ones; no idling in the last
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            timeout_val = 16'd0;
            hold_val    = 16'd0;
            count       = 150;
         end else if (p == 1) begin
            timeout_val = 16'hFFFF;
            hold_val    = 16'hFFFF;
            count       = 150;
         end else begin
            timeout_val = 16'($urandom_range(1, 40));
            hold_val    = 16'($urandom_range(0, 30));
            count       = 200;
         end
         settle();
         jitter_on = (p != PHASES - 1);
         write_limits(timeout_val, hold_val);
         for (int n = 0; n < count; n++) begin
            if (p == 2 && n == 100) hold_off_req = 1'b1;
            send_request(random_request());
         end
      end

      settle();
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("valve_actuator_supervisor verification clean");
      end else begin
         $display("valve_actuator_supervisor verification failed");
      end
      $finish;
   end

endmodule
